// ----- hw/rtl/mcptt_pkg.sv -----
// types and constants for the periodic tick timer bank
// no dependencies; imported by the interfaces and all modules
`timescale 1ns / 1ps

package mcptt_pkg;

  localparam int CMD_W    = 2;
  localparam int CHAN_W   = 2;
  localparam int PERIOD_W = 32;
  localparam int MASK_W   = 2;
  localparam int MS_W     = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_START = 2'd1,
    CMD_STOP  = 2'd2
  } cmd_t;

  // control from the top level to one channel
  typedef struct packed {
    logic                tick;
    logic                load;
    logic                active_set;
    logic [PERIOD_W-1:0] period;
  } chan_ctl_t;

  // status from one channel back to the top level
  typedef struct packed {
    logic active_nxt;
    logic fire;
  } chan_sts_t;

endpackage

// ----- hw/rtl/mcptt_if.sv -----
// valid/ready channel interfaces for command input and result output
// depends on mcptt_pkg
`timescale 1ns / 1ps

interface mcptt_in_if
  import mcptt_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [CHAN_W-1:0]   channel;
  logic [PERIOD_W-1:0] period_ms;
  logic                with_callback;

  modport source (output valid, cmd, channel, period_ms, with_callback, input ready);
  modport sink   (input valid, cmd, channel, period_ms, with_callback, output ready);
endinterface

interface mcptt_out_if
  import mcptt_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] fire_mask;
  logic [MS_W-1:0]   ms_count;
  logic              any_active;

  modport source (output valid, fire_mask, ms_count, any_active, input ready);
  modport sink   (input valid, fire_mask, ms_count, any_active, output ready);
endinterface

// ----- hw/rtl/mcptt_chan.sv -----
// one timer channel: active flag, tick count and interval
// depends on mcptt_pkg
`timescale 1ns / 1ps

module mcptt_chan
  import mcptt_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  chan_ctl_t ctl,
  output chan_sts_t sts
);

  logic                active_r, active_nxt;
  logic [PERIOD_W-1:0] count_r, count_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [PERIOD_W-1:0] count_inc;
  logic                fire;

  assign count_inc = count_r + PERIOD_W'(1);

  always_comb begin
    active_nxt = active_r;
    count_nxt  = count_r;
    period_nxt = period_r;
    fire       = 1'b0;
    if (ctl.load) begin
      active_nxt = ctl.active_set;
      count_nxt  = '0;
      period_nxt = ctl.period;
    end else if (ctl.tick && active_r) begin
      if (count_inc >= period_r) begin
        fire      = 1'b1;
        count_nxt = '0;
      end else begin
        count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      count_r  <= '0;
      period_r <= '0;
    end else begin
      active_r <= active_nxt;
      count_r  <= count_nxt;
      period_r <= period_nxt;
    end
  end

  assign sts.active_nxt = active_nxt;
  assign sts.fire       = fire;

endmodule

// ----- hw/rtl/multi_channel_periodic_tick_timer_top.sv -----
// top level of the periodic tick timer bank: input register, channel bank, result register
// depends on mcptt_pkg, mcptt_if and mcptt_chan
//
//   port     dir  fields                                      
//   in_bus   in   cmd, channel, period_ms, with_callback     
//   out_bus  out  fire_mask, ms_count, any_active            
//
// one item per cycle sustained unless out_bus.ready stalls; a command's result goes from
// the input register to the result register, and each of the two holds one item
// out_bus.ready stalls the result register and, through it, in_bus.ready
// synchronous active-low reset clears the counters, channels and valid flags
`timescale 1ns / 1ps

module multi_channel_periodic_tick_timer_top
  import mcptt_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  mcptt_in_if.sink           in_bus,
  mcptt_out_if.source        out_bus
);

  // input register
  logic                s1_valid_r;
  logic [CMD_W-1:0]    s1_cmd_r;
  logic [CHAN_W-1:0]   s1_chan_r;
  logic [PERIOD_W-1:0] s1_period_r;
  logic                s1_cb_r;

  // result register
  logic              out_valid_r;
  logic [MASK_W-1:0] out_fire_r, out_fire_nxt;
  logic [MS_W-1:0]   out_ms_r;
  logic              out_act_r;

  logic [MS_W-1:0]   millis_r, millis_nxt;
  logic              adv, step, is_tick, is_start, is_stop;
  logic [CHANNELS-1:0] fire_vec, active_vec;
  chan_ctl_t ctl [CHANNELS];
  chan_sts_t sts [CHANNELS];

  assign adv          = !out_valid_r || out_bus.ready;
  assign step         = adv && s1_valid_r;
  assign in_bus.ready = !s1_valid_r || adv;

  always_comb begin
    is_tick  = 1'b0;
    is_start = 1'b0;
    is_stop  = 1'b0;
    case (s1_cmd_r)
      CMD_TICK:  is_tick  = 1'b1;
      CMD_START: is_start = 1'b1;
      CMD_STOP:  is_stop  = 1'b1;
      default:   ;
    endcase
  end

  assign millis_nxt = is_tick ? millis_r + MS_W'(1) : millis_r;

  for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
    logic hit;
    assign hit = step && (s1_chan_r == CHAN_W'(c)) && (is_start || is_stop);
    assign ctl[c].tick       = step && is_tick;
    assign ctl[c].load       = hit;
    assign ctl[c].active_set = is_start && s1_cb_r;
    assign ctl[c].period     = is_start ? s1_period_r : '0;

    mcptt_chan u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .ctl   (ctl[c]),
      .sts   (sts[c])
    );

    assign fire_vec[c]   = sts[c].fire;
    assign active_vec[c] = sts[c].active_nxt;
  end

  // only the lowest channels reach the mask
  for (genvar m = 0; m < MASK_W; m++) begin : g_mask
    if (m < CHANNELS) begin : g_used
      assign out_fire_nxt[m] = fire_vec[m];
    end else begin : g_unused
      assign out_fire_nxt[m] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      millis_r    <= '0;
    end else begin
      if (in_bus.ready) begin
        s1_valid_r <= in_bus.valid;
      end
      if (adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (step) begin
        millis_r <= millis_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_cmd_r    <= in_bus.cmd;
      s1_chan_r   <= in_bus.channel;
      s1_period_r <= in_bus.period_ms;
      s1_cb_r     <= in_bus.with_callback;
    end
    if (step) begin
      out_fire_r <= out_fire_nxt;
      out_ms_r   <= millis_nxt;
      out_act_r  <= |active_vec;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.fire_mask  = out_fire_r;
  assign out_bus.ms_count   = out_ms_r;
  assign out_bus.any_active = out_act_r;

  a_no_fire_off_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !is_tick) |=> (out_fire_r == '0))
    else $error("fire mask set on a non-tick transfer");

  a_ms_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (step && is_tick) |=> (out_ms_r == MS_W'($past(millis_r) + MS_W'(1))))
    else $error("ms counter did not advance by one on tick");

  a_ms_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !is_tick) |=> (millis_r == $past(millis_r)))
    else $error("ms counter moved without a tick");

  a_fire_active: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_fire_r != '0)) |-> out_act_r)
    else $error("channel fired with no channel active");

endmodule

// ----- verif/timer_bank_check.sv -----
// result checker for the periodic tick timer bank: keeps its own copy of the
// timer state, predicts one result per command transfer and compares in order
// depends on mcptt_pkg and mcptt_if
`timescale 1ns / 1ps

module timer_bank_check
  import mcptt_pkg::*;
#(
  parameter int CHANNELS = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  mcptt_in_if         in_mon,
  mcptt_out_if        out_mon,
  output int unsigned fail_count,
  output int unsigned outstanding
);

  typedef struct packed {
    logic [MASK_W-1:0] fire_mask;
    logic [MS_W-1:0]   ms_count;
    logic              any_active;
  } timer_result_t;

  logic [MS_W-1:0]     ms_now;
  logic                run_flag [CHANNELS];
  logic [PERIOD_W-1:0] tick_cnt [CHANNELS];
  logic [PERIOD_W-1:0] interval [CHANNELS];

  timer_result_t pending_results [$];
  timer_result_t got;
  timer_result_t want;
  int unsigned   mismatches = 0;

  function automatic timer_result_t step_timer_bank(logic [CMD_W-1:0] op,
                                                    logic [CHAN_W-1:0] ch,
                                                    logic [PERIOD_W-1:0] per,
                                                    logic cb);
    timer_result_t r;
    logic [CHANNELS-1:0] fired;
    fired = '0;
    r = '0;
    case (cmd_t'(op))
      CMD_TICK: begin
        ms_now = ms_now + MS_W'(1);
        for (int c = 0; c < CHANNELS; c++) begin
          if (run_flag[c]) begin
            tick_cnt[c] = tick_cnt[c] + PERIOD_W'(1);
            if (tick_cnt[c] >= interval[c]) begin
              fired[c] = 1'b1;
              tick_cnt[c] = '0;
            end
          end
        end
      end
      CMD_START: begin
        if (int'(ch) < CHANNELS) begin
          tick_cnt[ch] = '0;
          interval[ch] = per;
          run_flag[ch] = cb;
        end
      end
      CMD_STOP: begin
        if (int'(ch) < CHANNELS) begin
          tick_cnt[ch] = '0;
          interval[ch] = '0;
          run_flag[ch] = 1'b0;
        end
      end
      default: ;
    endcase
    // only the two lowest channels reach the mask
    for (int c = 0; c < CHANNELS && c < MASK_W; c++) r.fire_mask[c] = fired[c];
    r.ms_count = ms_now;
    for (int c = 0; c < CHANNELS; c++) if (run_flag[c]) r.any_active = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      ms_now = '0;
      for (int c = 0; c < CHANNELS; c++) begin
        run_flag[c] = 1'b0;
        tick_cnt[c] = '0;
        interval[c] = '0;
      end
      pending_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.fire_mask  = out_mon.fire_mask;
        got.ms_count   = out_mon.ms_count;
        got.any_active = out_mon.any_active;
        if (pending_results.size() == 0) begin
          $display("%0t: result transfer with nothing expected, got %h", $time, got);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (got.fire_mask !== want.fire_mask) begin
            $display("%0t: fire_mask expected %h got %h", $time, want.fire_mask,
                     got.fire_mask);
            mismatches++;
          end
          if (got.ms_count !== want.ms_count) begin
            $display("%0t: ms_count expected %h got %h", $time, want.ms_count,
                     got.ms_count);
            mismatches++;
          end
          if (got.any_active !== want.any_active) begin
            $display("%0t: any_active expected %b got %b", $time, want.any_active,
                     got.any_active);
            mismatches++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        pending_results.push_back(step_timer_bank(in_mon.cmd, in_mon.channel,
                                                  in_mon.period_ms, in_mon.with_callback));
      end
    end
    fail_count  <= mismatches;
    outstanding <= pending_results.size();
  end

endmodule

// ----- verif/testbench.sv -----
// top of the periodic tick timer bank testbench: clock, reset, command
// stimulus with bursty sending and a stalling receiver, and the verdict
// depends on mcptt_pkg, mcptt_if, the timer bank top and timer_bank_check
`timescale 1ns / 1ps

module testbench;
  import mcptt_pkg::*;

  localparam int CHANNELS = 2;
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst_n;
  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned burst_left = 0;

  mcptt_in_if  in_bus ();
  mcptt_out_if out_bus ();

  multi_channel_periodic_tick_timer_top #(.CHANNELS(CHANNELS)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  timer_bank_check #(.CHANNELS(CHANNELS)) bank_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  // one transfer on the command channel, inside bursts with random gaps
  task automatic send_cmd(input logic [CMD_W-1:0] op, input logic [CHAN_W-1:0] ch,
                          input logic [PERIOD_W-1:0] per, input logic cb);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    in_bus.valid         <= 1'b1;
    in_bus.cmd           <= op;
    in_bus.channel       <= ch;
    in_bus.period_ms     <= per;
    in_bus.with_callback <= cb;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // the outstanding count is a registered copy of the checker's queue size, so it lags the last transfer
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // receiver stall pattern, chosen by bits 7:6 of a free-running cycle counter
  initial begin
    int unsigned cyc;
    cyc = 0;
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      case (cyc[7:6])
        2'd0: out_bus.ready <= 1'b1;
        2'd1: out_bus.ready <= ($urandom_range(0, 1) == 1);
        2'd2: out_bus.ready <= (cyc[1:0] == 2'd3);
        default: out_bus.ready <= ($urandom_range(0, 99) < 85);
      endcase
      cyc++;
    end
  end

  initial begin
    int unsigned r;
    logic [CMD_W-1:0]    op;
    logic [CHAN_W-1:0]   ch;
    logic [PERIOD_W-1:0] per;
    logic                cb;
    rst_n                <= 1'b0;
    in_bus.valid         <= 1'b0;
    in_bus.cmd           <= CMD_TICK;
    in_bus.channel       <= '0;
    in_bus.period_ms     <= '0;
    in_bus.with_callback <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    send_cmd(CMD_TICK, 2'd0, 32'd0, 1'b0);
    send_cmd(CMD_START, 2'd0, 32'd0, 1'b1);
    send_cmd(CMD_TICK, 2'd0, 32'd0, 1'b0);
    send_cmd(CMD_TICK, 2'd0, 32'd0, 1'b0);
    send_cmd(CMD_START, 2'd1, 32'd3, 1'b1);
    repeat (3) send_cmd(CMD_TICK, 2'd1, 32'd0, 1'b0);
    send_cmd(CMD_START, 2'd0, 32'd5, 1'b0);
    send_cmd(CMD_TICK, 2'd0, 32'd0, 1'b0);
    send_cmd(CMD_START, 2'd2, 32'd1, 1'b1);
    send_cmd(CMD_STOP, 2'd3, 32'd0, 1'b0);
    send_cmd(CMD_START, 2'd3, 32'd0, 1'b1);
    send_cmd(CMD_SPARE, 2'd0, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_START, 2'd1, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_TICK, 2'd3, 32'hFFFF_FFFF, 1'b1);
    send_cmd(CMD_STOP, 2'd0, 32'd0, 1'b0);
    send_cmd(CMD_STOP, 2'd1, 32'd0, 1'b0);
    send_cmd(CMD_TICK, 2'd0, 32'd0, 1'b0);
    send_cmd(CMD_START, 2'd1, 32'd1, 1'b1);
    send_cmd(CMD_TICK, 2'd0, 32'd0, 1'b0);
    send_cmd(CMD_STOP, 2'd2, 32'd0, 1'b0);
    drain_results();

    // random part, mostly ticks with short intervals so channels fire often
    for (int i = 0; i < 600; i++) begin
      r = $urandom_range(0, 99);
      if (r < 62)      op = CMD_TICK;
      else if (r < 84) op = CMD_START;
      else if (r < 95) op = CMD_STOP;
      else             op = CMD_SPARE;
      ch = CHAN_W'(($urandom_range(0, 99) < 85) ? $urandom_range(0, 1)
                                                : $urandom_range(2, 3));
      r = $urandom_range(0, 99);
      if (r < 65)      per = $urandom_range(0, 6);
      else if (r < 80) per = $urandom;
      else if (r < 88) per = 32'hFFFF_FFFF - $urandom_range(0, 3);
      else             per = $urandom_range(7, 40);
      cb = ($urandom_range(0, 9) != 0);
      send_cmd(op, ch, per, cb);
      if (i % 200 == 199) drain_results();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench NOT OK");
    $finish;
  end

endmodule
